/* rtl/core/pidh_pkg.sv */
package pidh_pkg;

   // Configuration register map and codes.
   localparam int unsigned CSR_ADDR_W = 2;
   localparam logic [CSR_ADDR_W-1:0] CSR_ADDR_FORMAT = 2'd0;
   localparam logic [1:0] FMT_SHORT_ID = 2'd1;
   localparam logic [1:0] FMT_RESET = 2'd2;

   // Remembered state after reset or restart.
   localparam logic [15:0] NODE_NONE = 16'hFFFF;
   localparam logic [31:0] STAMP_NONE = 32'h0000_0000;

   // Compact unsigned integer prefixes.
   localparam logic [7:0] PACK_U8 = 8'hCC;
   localparam logic [7:0] PACK_U16 = 8'hCD;
   localparam logic [15:0] PACK_FIX_MAX = 16'h007F;
   localparam logic [15:0] PACK_U8_MAX = 16'h00FF;

   // Fixed byte slots of one encoded identifier, in transmit order.
   localparam int unsigned NUM_SLOTS = 11;
   localparam int unsigned SLOT_PFX = 0;
   localparam int unsigned SLOT_HI = 1;
   localparam int unsigned SLOT_LO = 2;
   localparam int unsigned SLOT_OFFS = 3;
   localparam int unsigned SLOT_NODE_HI = 4;
   localparam int unsigned SLOT_NODE_LO = 5;
   localparam int unsigned SLOT_STAMP_3 = 6;
   localparam int unsigned SLOT_STAMP_2 = 7;
   localparam int unsigned SLOT_STAMP_1 = 8;
   localparam int unsigned SLOT_STAMP_0 = 9;
   localparam int unsigned SLOT_EXT = 10;

   // Queue between the front and the back.
   localparam int unsigned QDEPTH = 2;
   localparam int unsigned QPTR_W = $clog2(QDEPTH);
   localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

   // One classified identifier: which slots are sent and their bytes.
   typedef struct packed {
      logic [NUM_SLOTS-1:0]      mask;
      logic [NUM_SLOTS-1:0][7:0] bytes;
   } desc_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;

endpackage

/* rtl/core/pidh_front.sv */
module pidh_front
   import pidh_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic [1:0]  format_version,
   input  logic        accept,
   input  logic [15:0] param_id,
   input  logic [15:0] node_addr,
   input  logic [31:0] stamp,
   input  logic        has_offset,
   input  logic [7:0]  elem_offset,
   input  logic        restart,
   output desc_type    desc
);

   logic [15:0] prev_node_ff, prev_node_in;
   logic [31:0] prev_stamp_ff, prev_stamp_in;
   logic [15:0] base_node;
   logic [31:0] base_stamp;
   logic        short_fmt;
   logic        nflag, tflag, xflag;
   logic [15:0] hdr;
   logic [15:0] value;

   // A restart clears the remembered node and stamp before this transaction.
   assign base_node = restart ? NODE_NONE : prev_node_ff;
   assign base_stamp = restart ? STAMP_NONE : prev_stamp_ff;
   assign short_fmt = (format_version == FMT_SHORT_ID);

   // Delta header flags and the byte-swapped header word.
   assign nflag = (base_node != node_addr);
   assign tflag = (base_stamp != stamp);
   assign xflag = |param_id[15:10];
   assign hdr = {has_offset, nflag, tflag, xflag, 2'b00, param_id[9:0]};

   // The short id keeps five node bits and nine id bits.
   assign value = short_fmt ? {node_addr[4:0], has_offset, 1'b0, param_id[8:0]}
                            : {hdr[7:0], hdr[15:8]};

   // Fill every slot and mark the ones that are sent.
   always_comb begin
      desc = '0;
      desc.bytes[SLOT_PFX] = (value > PACK_U8_MAX) ? PACK_U16 : PACK_U8;
      desc.bytes[SLOT_HI] = value[15:8];
      desc.bytes[SLOT_LO] = value[7:0];
      desc.bytes[SLOT_OFFS] = elem_offset;
      desc.bytes[SLOT_NODE_HI] = node_addr[15:8];
      desc.bytes[SLOT_NODE_LO] = node_addr[7:0];
      desc.bytes[SLOT_STAMP_3] = stamp[31:24];
      desc.bytes[SLOT_STAMP_2] = stamp[23:16];
      desc.bytes[SLOT_STAMP_1] = stamp[15:8];
      desc.bytes[SLOT_STAMP_0] = stamp[7:0];
      desc.bytes[SLOT_EXT] = {param_id[15:10], 2'b00};
      desc.mask[SLOT_PFX] = (value > PACK_FIX_MAX);
      desc.mask[SLOT_HI] = (value > PACK_U8_MAX);
      desc.mask[SLOT_LO] = 1'b1;
      desc.mask[SLOT_OFFS] = has_offset;
      desc.mask[SLOT_NODE_HI] = !short_fmt && nflag;
      desc.mask[SLOT_NODE_LO] = !short_fmt && nflag;
      desc.mask[SLOT_STAMP_3] = !short_fmt && tflag;
      desc.mask[SLOT_STAMP_2] = !short_fmt && tflag;
      desc.mask[SLOT_STAMP_1] = !short_fmt && tflag;
      desc.mask[SLOT_STAMP_0] = !short_fmt && tflag;
      desc.mask[SLOT_EXT] = !short_fmt && xflag;
   end

   // The delta format always leaves the current node and stamp remembered.
   always_comb begin
      prev_node_in = prev_node_ff;
      prev_stamp_in = prev_stamp_ff;
      if (accept) begin
         prev_node_in = short_fmt ? base_node : node_addr;
         prev_stamp_in = short_fmt ? base_stamp : stamp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_node_ff <= NODE_NONE;
         prev_stamp_ff <= STAMP_NONE;
      end else begin
         prev_node_ff <= prev_node_in;
         prev_stamp_ff <= prev_stamp_in;
      end
   end

endmodule

/* rtl/core/pidh_queue.sv */
module pidh_queue
   import pidh_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  desc_type   push_data,
   input  logic       pop,
   output desc_type   pop_data,
   output q_stat_type stat
);

   desc_type            mem [QDEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                do_push, do_pop;

   assign stat.full = (count_ff == QCNT_W'(QDEPTH));
   assign stat.empty = (count_ff == '0);
   assign do_push = push && !stat.full;
   assign do_pop = pop && !stat.empty;
   assign pop_data = mem[rd_ptr_ff];

   // Pointer wrap and occupancy.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   // Storage for the classified transactions.
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* rtl/core/pidh_back.sv */
module pidh_back
   import pidh_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  desc_type   q_data,
   input  q_stat_type q_stat,
   output logic       q_pop,
   output logic       out_valid,
   output logic [7:0] out_byte,
   output logic       out_last,
   input  logic       out_pop
);

   logic [NUM_SLOTS-1:0]      cur_mask_ff, cur_mask_in;
   logic [NUM_SLOTS-1:0][7:0] cur_bytes_ff, cur_bytes_in;
   logic                      out_valid_ff, out_valid_in;
   logic [7:0]                out_byte_ff, out_byte_in;
   logic                      out_last_ff, out_last_in;
   logic [NUM_SLOTS-1:0]      first_hot, rest_mask;
   logic [7:0]                sel_byte;
   logic                      out_free, emit, load;

   // Next slot to send is the lowest one still marked.
   assign first_hot = cur_mask_ff & (~cur_mask_ff + 1'b1);
   assign rest_mask = cur_mask_ff & ~first_hot;

   always_comb begin
      sel_byte = '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         sel_byte = sel_byte | (cur_bytes_ff[i] & {8{first_hot[i]}});
      end
   end

   // One byte moves into the output register whenever one is pending and the register is free or being taken.
   assign out_free = !out_valid_ff || out_pop;
   assign emit = (cur_mask_ff != '0) && out_free;
   assign load = !q_stat.empty && ((cur_mask_ff == '0) || (emit && (rest_mask == '0)));
   assign q_pop = load;

   always_comb begin
      cur_mask_in = cur_mask_ff;
      cur_bytes_in = cur_bytes_ff;
      out_valid_in = out_valid_ff;
      out_byte_in = out_byte_ff;
      out_last_in = out_last_ff;
      if (out_pop) begin
         out_valid_in = 1'b0;
      end
      if (emit) begin
         cur_mask_in = rest_mask;
         out_valid_in = 1'b1;
         out_byte_in = sel_byte;
         out_last_in = (rest_mask == '0);
      end
      if (load) begin
         cur_mask_in = q_data.mask;
         cur_bytes_in = q_data.bytes;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_mask_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         cur_mask_ff <= cur_mask_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_bytes_ff <= cur_bytes_in;
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
   end

   assign out_valid = out_valid_ff;
   assign out_byte = out_byte_ff;
   assign out_last = out_last_ff;

endmodule

/* rtl/core/param_id_header_delta_encoder_core.sv */
// The first byte of a transaction passes through the queue, the serializer's held identifier
// and the output register. Throughput: one byte per cycle while rsp_pop takes them, set by the
// single byte-wide output; an identifier is 1 to 11 bytes, and queued ones follow without a gap.
// A two-entry queue lets the input side run ahead of the byte serializer.
// Reset is synchronous: the queue and serializer empty, the node and stamp memory return to
// "no node" and zero, and the format register returns to the delta header format.
module param_id_header_delta_encoder_core
   import pidh_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // Input channel.
   input  logic                  req_push,
   output logic                  req_full,
   input  logic [15:0]           req_param_id,
   input  logic [15:0]           req_node_addr,
   input  logic [31:0]           req_stamp,
   input  logic                  req_has_offset,
   input  logic [7:0]            req_elem_offset,
   input  logic                  req_restart,
   // Result channel.
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output logic [7:0]            rsp_out_byte,
   output logic                  rsp_last_byte,
   // Configuration port.
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   logic [1:0]  format_ff, format_in;
   logic        csr_wr;
   logic        req_accept;
   desc_type    front_desc, q_head;
   q_stat_type  q_stat;
   logic        q_pop;
   logic        out_valid;

   // Configuration register.
   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign format_in = (csr_wr && (csr_paddr == CSR_ADDR_FORMAT)) ? csr_pwdata[1:0] : format_ff;
   assign csr_prdata = (csr_paddr == CSR_ADDR_FORMAT) ? {30'd0, format_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         format_ff <= FMT_RESET;
      end else begin
         format_ff <= format_in;
      end
   end

   assign req_full = q_stat.full;
   assign req_accept = req_push && !q_stat.full;

   pidh_front u_front (
      .clock          (clock),
      .reset          (reset),
      .format_version (format_ff),
      .accept         (req_accept),
      .param_id       (req_param_id),
      .node_addr      (req_node_addr),
      .stamp          (req_stamp),
      .has_offset     (req_has_offset),
      .elem_offset    (req_elem_offset),
      .restart        (req_restart),
      .desc           (front_desc)
   );

   pidh_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_accept),
      .push_data (front_desc),
      .pop       (q_pop),
      .pop_data  (q_head),
      .stat      (q_stat)
   );

   pidh_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_data    (q_head),
      .q_stat    (q_stat),
      .q_pop     (q_pop),
      .out_valid (out_valid),
      .out_byte  (rsp_out_byte),
      .out_last  (rsp_last_byte),
      .out_pop   (rsp_pop)
   );

   assign rsp_empty = !out_valid;

   // A taken byte that is not the last one is followed at once by the next.
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_pop && !rsp_last_byte) |=> !rsp_empty)
      else $error("result stream stalled inside a transaction");

   // An accepted transaction is held in the queue on the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_accept |=> !q_stat.empty)
      else $error("accepted transaction missing from the queue");

   // A write to the format register takes effect on the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (csr_wr && (csr_paddr == CSR_ADDR_FORMAT)) |=> (format_ff == $past(csr_pwdata[1:0])))
      else $error("format register write lost");

   // The queue never reports full and empty together.
   assert property (@(posedge clock) disable iff (reset)
      !(q_stat.full && q_stat.empty))
      else $error("queue status inconsistent");

endmodule

/* dv/param_id_header_delta_encoder_core_tb.sv */
module param_id_header_delta_encoder_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import pidh_pkg::*;

   // Format codes that the package does not name.
   localparam logic [1:0] FMT_DELTA_HDR = FMT_RESET;
   localparam logic [1:0] FMT_UNUSED_ZERO = 2'd0;
   localparam logic [1:0] FMT_UNUSED_THREE = 2'd3;

   localparam int unsigned RESET_CYCLES = 12;
   localparam int unsigned WATCHDOG_LIMIT = 2000;
   localparam int unsigned RX_STALL_CYCLES = 80;
   localparam int unsigned TAIL_CYCLES = 16;
   localparam int unsigned RAND_CHUNK = 40;

   // One identifier as offered on the input channel.
   typedef struct packed {
      logic [15:0] param_id;
      logic [15:0] node_addr;
      logic [31:0] stamp;
      logic        has_offset;
      logic [7:0]  elem_offset;
      logic        restart;
   } param_ident_type;

   // One serialized byte as expected on the result channel.
   typedef struct packed {
      logic [7:0] data;
      logic       is_last;
   } enc_byte_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_push = 1'b0;
   logic                  req_full;
   logic [15:0]           req_param_id = '0;
   logic [15:0]           req_node_addr = '0;
   logic [31:0]           req_stamp = '0;
   logic                  req_has_offset = 1'b0;
   logic [7:0]            req_elem_offset = '0;
   logic                  req_restart = 1'b0;
   logic                  rsp_empty;
   logic                  rsp_pop = 1'b0;
   logic [7:0]            rsp_out_byte;
   logic                  rsp_last_byte;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [31:0]           csr_pwdata = '0;
   logic [31:0]           csr_prdata;
   logic                  csr_pready;

   // Predictor state: format register and the remembered node and stamp.
   logic [1:0]  model_format = FMT_RESET;
   logic [15:0] seen_node = NODE_NONE;
   logic [31:0] seen_stamp = STAMP_NONE;

   enc_byte_type pending_bytes[$];
   int unsigned  error_count = 0;
   int unsigned  send_idle_pct = 0;
   int unsigned  recv_idle_pct = 0;
   int unsigned  stall_left = 0;
   bit           stall_request = 1'b0;
   int unsigned  quiet_cycles = 0;

   param_id_header_delta_encoder_core u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_param_id    (req_param_id),
      .req_node_addr   (req_node_addr),
      .req_stamp       (req_stamp),
      .req_has_offset  (req_has_offset),
      .req_elem_offset (req_elem_offset),
      .req_restart     (req_restart),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_last_byte   (rsp_last_byte),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready)
   );

   // Free-running clock.
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Works out the bytes that one accepted identifier produces and queues them.
   task automatic predict_id_bytes(input param_ident_type it);
      logic [7:0]   enc[$];
      logic [15:0]  hdr;
      logic [15:0]  word;
      logic         node_chg;
      logic         stamp_chg;
      logic         ext_id;
      enc_byte_type eb;
      int           i;
      if (it.restart) begin
         seen_node = NODE_NONE;
         seen_stamp = STAMP_NONE;
      end
      node_chg = (seen_node != it.node_addr);
      stamp_chg = (seen_stamp != it.stamp);
      ext_id = (it.param_id[15:10] != 6'd0);
      if (model_format == FMT_SHORT_ID) begin
         word = {it.node_addr[4:0], it.has_offset, 1'b0, it.param_id[8:0]};
      end else begin
         hdr = {it.has_offset, node_chg, stamp_chg, ext_id, 2'b00, it.param_id[9:0]};
         // The header goes out byte-swapped, as a little-endian host stores it.
         word = {hdr[7:0], hdr[15:8]};
      end
      // Minimal compact unsigned integer encoding of the 16-bit word.
      if (word <= PACK_FIX_MAX) begin
         enc.push_back(word[7:0]);
      end else if (word <= PACK_U8_MAX) begin
         enc.push_back(PACK_U8);
         enc.push_back(word[7:0]);
      end else begin
         enc.push_back(PACK_U16);
         enc.push_back(word[15:8]);
         enc.push_back(word[7:0]);
      end
      if (it.has_offset) begin
         enc.push_back(it.elem_offset);
      end
      // The delta header format sends only what changed and the extended id.
      if (model_format != FMT_SHORT_ID) begin
         if (node_chg) begin
            seen_node = it.node_addr;
            enc.push_back(it.node_addr[15:8]);
            enc.push_back(it.node_addr[7:0]);
         end
         if (stamp_chg) begin
            seen_stamp = it.stamp;
            enc.push_back(it.stamp[31:24]);
            enc.push_back(it.stamp[23:16]);
            enc.push_back(it.stamp[15:8]);
            enc.push_back(it.stamp[7:0]);
         end
         if (ext_id) begin
            enc.push_back({it.param_id[15:10], 2'b00});
         end
      end
      for (i = 0; i < enc.size(); i++) begin
         eb.data = enc[i];
         eb.is_last = (i == enc.size() - 1);
         pending_bytes.push_back(eb);
      end
   endtask

   function automatic param_ident_type ident(input logic [15:0] id, input logic [15:0] node,
                                             input logic [31:0] stamp, input logic offs_en,
                                             input logic [7:0] offs, input logic rst);
      param_ident_type it;
      it.param_id = id;
      it.node_addr = node;
      it.stamp = stamp;
      it.has_offset = offs_en;
      it.elem_offset = offs;
      it.restart = rst;
      return it;
   endfunction

   // Random identifier, biased toward repeated nodes and stamps and short headers.
   function automatic param_ident_type random_ident();
      param_ident_type it;
      logic [31:0]     rnd;
      int unsigned     sel;
      rnd = $urandom;
      sel = $urandom_range(9);
      if (sel < 3) begin
         it.param_id = {rnd[15:8], 8'h00};
      end else if (sel < 6) begin
         it.param_id = {6'd0, rnd[9:0]};
      end else if (sel == 6) begin
         it.param_id = rnd[16] ? 16'hFFFF : 16'h0000;
      end else begin
         it.param_id = rnd[15:0];
      end
      rnd = $urandom;
      sel = $urandom_range(9);
      if (sel < 4) begin
         it.node_addr = seen_node;
      end else if (sel == 4) begin
         it.node_addr = NODE_NONE;
      end else if (sel == 5) begin
         it.node_addr = {rnd[15:5], 5'd0};
      end else begin
         it.node_addr = rnd[15:0];
      end
      rnd = $urandom;
      sel = $urandom_range(9);
      if (sel < 4) begin
         it.stamp = seen_stamp;
      end else if (sel == 4) begin
         it.stamp = STAMP_NONE;
      end else if (sel == 5) begin
         it.stamp = 32'hFFFF_FFFF;
      end else begin
         it.stamp = rnd;
      end
      rnd = $urandom;
      it.has_offset = rnd[0];
      it.elem_offset = rnd[8:1];
      it.restart = ($urandom_range(9) == 0);
      return it;
   endfunction

   // Offers one identifier and records its bytes once the block takes it.
   task automatic send_item(input param_ident_type it);
      while ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(negedge clock);
      end
      req_push <= 1'b1;
      req_param_id <= it.param_id;
      req_node_addr <= it.node_addr;
      req_stamp <= it.stamp;
      req_has_offset <= it.has_offset;
      req_elem_offset <= it.elem_offset;
      req_restart <= it.restart;
      do @(posedge clock); while (req_full);
      predict_id_bytes(it);
      @(negedge clock);
   endtask

   // Stops offering and waits until every expected byte has been taken.
   task automatic end_burst();
      req_push <= 1'b0;
      while (pending_bytes.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   // Writes the format register; the upper data bits carry noise.
   task automatic write_format(input logic [1:0] fmt);
      logic [31:0] rnd;
      rnd = $urandom;
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= CSR_ADDR_FORMAT;
      csr_pwdata <= {rnd[31:2], fmt};
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      model_format = fmt;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   // Delta header format from its reset value: header sizes, flags and the longest string.
   task automatic test_delta_header();
      send_item(ident(16'h0000, 16'hFFFF, 32'h0000_0000, 1'b0, 8'h00, 1'b0));
      send_item(ident(16'h0300, 16'hFFFF, 32'h0000_0000, 1'b0, 8'h00, 1'b0));
      send_item(ident(16'h0200, 16'hFFFF, 32'h0000_0000, 1'b1, 8'hA5, 1'b0));
      send_item(ident(16'h03FF, 16'h1234, 32'hDEAD_BEEF, 1'b0, 8'h00, 1'b0));
      send_item(ident(16'h0400, 16'h1234, 32'hDEAD_BEEF, 1'b0, 8'h00, 1'b0));
      send_item(ident(16'hFFFF, 16'h0000, 32'hFFFF_FFFF, 1'b1, 8'hFF, 1'b0));
      send_item(ident(16'h0100, 16'hFFFF, 32'h0000_0000, 1'b0, 8'h00, 1'b1));
      send_item(ident(16'hFC00, 16'hFFFF, 32'h0000_0001, 1'b1, 8'h00, 1'b0));
      end_burst();
   endtask

   // Short id format: truncated node and id, packed sizes, restart still clears memory.
   task automatic test_short_id();
      write_format(FMT_SHORT_ID);
      send_item(ident(16'h0000, 16'h0000, 32'h0000_0000, 1'b0, 8'h00, 1'b0));
      send_item(ident(16'h007F, 16'h0020, 32'h1111_1111, 1'b0, 8'h00, 1'b0));
      send_item(ident(16'h0080, 16'h0000, 32'h0000_0000, 1'b0, 8'h00, 1'b0));
      send_item(ident(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, 8'hFF, 1'b0));
      send_item(ident(16'h0155, 16'h0020, 32'h0000_0000, 1'b1, 8'h00, 1'b0));
      send_item(ident(16'hFE00, 16'h7FE0, 32'h0000_0007, 1'b0, 8'h00, 1'b1));
      end_burst();
   endtask

   // The two unused format codes behave like the delta header format.
   task automatic test_unused_formats();
      write_format(FMT_UNUSED_ZERO);
      send_item(ident(16'h0000, 16'hFFFF, 32'h0000_0000, 1'b0, 8'h00, 1'b0));
      send_item(ident(16'h0401, 16'h0005, 32'h0000_0000, 1'b0, 8'h00, 1'b0));
      end_burst();
      write_format(FMT_UNUSED_THREE);
      send_item(ident(16'h00FF, 16'h0005, 32'h8000_0000, 1'b1, 8'h5A, 1'b0));
      send_item(ident(16'h0000, 16'h0005, 32'h8000_0000, 1'b1, 8'h00, 1'b0));
      end_burst();
      write_format(FMT_DELTA_HDR);
   endtask

   // The receiver holds off for a long stretch while identifiers keep coming.
   task automatic test_input_stall();
      int unsigned k;
      stall_request = 1'b1;
      for (k = 0; k < 16; k++) begin
         send_item(random_ident());
      end
      end_burst();
   endtask

   // Random identifiers in chunks, with a format write before each chunk.
   task automatic test_random_traffic(input int unsigned n_items);
      int unsigned k;
      logic [1:0]  fmt;
      for (k = 0; k < n_items; k++) begin
         if (k % RAND_CHUNK == 0) begin
            if (k / RAND_CHUNK == 1) begin
               fmt = FMT_SHORT_ID;
            end else begin
               case ($urandom_range(5))
                  0: fmt = FMT_SHORT_ID;
                  1: fmt = FMT_UNUSED_ZERO;
                  2: fmt = FMT_UNUSED_THREE;
                  default: fmt = FMT_DELTA_HDR;
               endcase
            end
            end_burst();
            write_format(fmt);
         end
         send_item(random_ident());
      end
      end_burst();
   endtask

   // Receiver: random pop, or a counted hold-off when one is requested.
   always @(negedge clock) begin
      if (stall_request) begin
         stall_request = 1'b0;
         stall_left = RX_STALL_CYCLES;
      end
      if (reset || stall_left != 0) begin
         rsp_pop <= 1'b0;
         if (stall_left != 0) begin
            stall_left = stall_left - 1;
         end
      end else begin
         rsp_pop <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Compares each accepted byte with the oldest expected one.
   always @(posedge clock) begin
      enc_byte_type exp_byte;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (pending_bytes.size() == 0) begin
            $display("%0t: unexpected transaction, out_byte %02h last_byte %0b", $time,
                     rsp_out_byte, rsp_last_byte);
            error_count++;
         end else begin
            exp_byte = pending_bytes.pop_front();
            if (rsp_out_byte !== exp_byte.data) begin
               $display("%0t: out_byte mismatch, expected %02h, actual %02h", $time,
                        exp_byte.data, rsp_out_byte);
               error_count++;
            end
            if (rsp_last_byte !== exp_byte.is_last) begin
               $display("%0t: last_byte mismatch, expected %0b, actual %0b", $time,
                        exp_byte.is_last, rsp_last_byte);
               error_count++;
            end
         end
      end
   end

   // Watchdog: ends the run after too many cycles without any transaction.
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
         $display("param_id_header_delta_encoder_core regression: fail");
         $finish;
      end
   end

   // Test sequence.
   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Sender idles lightly, receiver heavily.
      send_idle_pct = 14;
      recv_idle_pct = 46;
      test_delta_header();
      test_short_id();
      test_unused_formats();
      test_input_stall();
      test_random_traffic(160);

      // Sender idles heavily, receiver lightly.
      send_idle_pct = 46;
      recv_idle_pct = 14;
      test_random_traffic(160);

      // Neither side idles.
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_traffic(160);

      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0 && pending_bytes.size() == 0) begin
         $display("param_id_header_delta_encoder_core regression: pass");
      end else begin
         $display("param_id_header_delta_encoder_core regression: fail");
      end
      $finish;
   end

endmodule
